// ===== rtl/core/bspm_pkg.sv =====
`default_nettype none
package bspm_pkg;

    localparam int MAX_LEN_DEFAULT = 1024;
    localparam int POS_W           = 10;
    localparam int NKINDS          = 4;

    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;  // <
    localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;  // >
    localparam logic [7:0] CH_BREAK        = 8'h2B;  // +

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_CURLY  = 2'd1;
    localparam logic [1:0] KIND_SQUARE = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [1:0] ST_PAIR      = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef struct packed {
        logic       is_bracket;
        logic       is_open;
        logic [1:0] kind;
    } sym_class_t;

    // result waiting for the stack read to return
    typedef struct packed {
        logic             is_pair;
        logic [POS_W-1:0] close_pos;
        logic [1:0]       kind;
        logic [1:0]       status;
    } pend_t;

    function automatic sym_class_t classify(input logic [7:0] sym);
        sym_class_t c;
        c = '{is_bracket: 1'b1, is_open: 1'b1, kind: KIND_ROUND};
        unique case (sym)
            CH_ROUND_OPEN:   c = '{1'b1, 1'b1, KIND_ROUND};
            CH_ROUND_CLOSE:  c = '{1'b1, 1'b0, KIND_ROUND};
            CH_CURLY_OPEN:   c = '{1'b1, 1'b1, KIND_CURLY};
            CH_CURLY_CLOSE:  c = '{1'b1, 1'b0, KIND_CURLY};
            CH_SQUARE_OPEN:  c = '{1'b1, 1'b1, KIND_SQUARE};
            CH_SQUARE_CLOSE: c = '{1'b1, 1'b0, KIND_SQUARE};
            CH_ANGLE_OPEN:   c = '{1'b1, 1'b1, KIND_ANGLE};
            CH_ANGLE_CLOSE:  c = '{1'b1, 1'b0, KIND_ANGLE};
            default:         c = '{1'b0, 1'b0, KIND_ROUND};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bspm_ram.sv =====
`default_nettype none
module bspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bspm_stack_ctrl.sv =====
`default_nettype none
module bspm_stack_ctrl #(
    parameter int MAX_LEN = bspm_pkg::MAX_LEN_DEFAULT,
    parameter int AW      = $clog2(MAX_LEN),
    parameter int MW      = AW + 2
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [7:0]                s_symbol,
    input  wire logic                      s_last,
    output logic                           mem_we,
    output logic      [MW-1:0]             mem_waddr,
    output logic      [bspm_pkg::POS_W-1:0] mem_wdata,
    output logic                           mem_re,
    output logic      [MW-1:0]             mem_raddr,
    input  wire logic                      pend_take,
    output logic                           pend_valid,
    output bspm_pkg::pend_t                pend
);

    localparam int PW = $clog2(MAX_LEN + 1);

    logic [PW-1:0] depth_reg [bspm_pkg::NKINDS];
    logic [PW-1:0] depth_next [bspm_pkg::NKINDS];
    logic [PW-1:0] pos_reg, pos_next;
    logic          err_reg, err_next;
    logic          pend_valid_reg, pend_valid_next;
    bspm_pkg::pend_t pend_reg, pend_next;

    bspm_pkg::sym_class_t cls;
    logic          accept, active, too_long, push, pop, unmatched, has_result;
    logic [PW-1:0] depth_cur, depth_dec;

    assign s_ready = !pend_valid_reg || pend_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cls        = bspm_pkg::classify(s_symbol);
        active     = !err_reg && (s_symbol != bspm_pkg::CH_BREAK);
        too_long   = pos_reg >= PW'(MAX_LEN);
        depth_cur  = depth_reg[cls.kind];
        depth_dec  = depth_cur - PW'(1);
        push       = active && !too_long && cls.is_bracket && cls.is_open
                     && (depth_cur < PW'(MAX_LEN));
        pop        = active && !too_long && cls.is_bracket && !cls.is_open
                     && (depth_cur != '0);
        unmatched  = active && !too_long && cls.is_bracket && !cls.is_open
                     && (depth_cur == '0);
        has_result = active && (too_long || (cls.is_bracket && !cls.is_open));
    end

    // a beat does either a push or a pop, so a pop right after a push
    // reads the freshly written entry without forwarding
    assign mem_we    = accept && push;
    assign mem_waddr = {cls.kind, depth_cur[AW-1:0]};
    assign mem_wdata = bspm_pkg::POS_W'(pos_reg);
    assign mem_re    = accept && pop;
    assign mem_raddr = {cls.kind, depth_dec[AW-1:0]};

    always_comb begin
        depth_next      = depth_reg;
        pos_next        = pos_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg && !pend_take;
        pend_next       = pend_reg;
        if (accept) begin
            if (push) begin
                depth_next[cls.kind] = depth_cur + PW'(1);
            end
            if (pop) begin
                depth_next[cls.kind] = depth_dec;
            end
            if (active && !too_long) begin
                pos_next = pos_reg + PW'(1);
            end
            if ((active && too_long) || unmatched) begin
                err_next = 1'b1;
            end
            if (has_result) begin
                pend_valid_next    = 1'b1;
                pend_next.is_pair  = pop;
                pend_next.close_pos = bspm_pkg::POS_W'(pos_reg);
                pend_next.kind     = too_long ? bspm_pkg::KIND_ROUND : cls.kind;
                pend_next.status   = too_long ? bspm_pkg::ST_TOO_LONG :
                                     unmatched ? bspm_pkg::ST_UNMATCHED :
                                     bspm_pkg::ST_PAIR;
            end
            // clear the structure state after its final beat
            if (s_last) begin
                for (int k = 0; k < bspm_pkg::NKINDS; k++) begin
                    depth_next[k] = '0;
                end
                pos_next = '0;
                err_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < bspm_pkg::NKINDS; k++) begin
                depth_reg[k] <= '0;
            end
            pos_reg        <= '0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            depth_reg      <= depth_next;
            pos_reg        <= pos_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
        end
        pend_reg <= pend_next;
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

    a_pop_gives_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> (pend_valid_reg && pend_reg.is_pair))
        else $error("pop without pending pair");

    a_pend_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !pend_take) |=> (pend_valid_reg && $stable(pend_reg)))
        else $error("pending result lost while stalled");

    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("push and pop in one beat");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> ((pos_reg == '0) && !err_reg))
        else $error("state not cleared after last beat");

endmodule
`default_nettype wire

// ===== rtl/core/bspm_out_stage.sv =====
`default_nettype none
module bspm_out_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       pend_valid,
    input  wire bspm_pkg::pend_t            pend,
    input  wire logic [bspm_pkg::POS_W-1:0] stack_rdata,
    output logic                            pend_take,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [bspm_pkg::POS_W-1:0] m_open_pos,
    output logic      [bspm_pkg::POS_W-1:0] m_close_pos,
    output logic      [1:0]                 m_bracket_kind,
    output logic      [1:0]                 m_status
);

    logic                       valid_reg, valid_next;
    logic [bspm_pkg::POS_W-1:0] open_reg, open_next;
    logic [bspm_pkg::POS_W-1:0] close_reg, close_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [1:0]                 status_reg, status_next;
    logic                       load;

    assign pend_take = !valid_reg || m_ready;
    assign load      = pend_valid && pend_take;

    always_comb begin
        valid_next  = valid_reg && !m_ready;
        open_next   = open_reg;
        close_next  = close_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        if (load) begin
            valid_next  = 1'b1;
            // stack read data is held until the next pop
            open_next   = pend.is_pair ? stack_rdata : '0;
            close_next  = pend.close_pos;
            kind_next   = pend.kind;
            status_next = pend.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        open_reg   <= open_next;
        close_reg  <= close_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
    end

    assign m_valid        = valid_reg;
    assign m_open_pos     = open_reg;
    assign m_close_pos    = close_reg;
    assign m_bracket_kind = kind_reg;
    assign m_status       = status_reg;

endmodule
`default_nettype wire

// ===== rtl/core/bracket_structure_pair_matcher.sv =====
// channel   direction  ports
// s_        in         s_valid s_ready s_symbol[7:0] s_last
// m_        out        m_valid m_ready m_open_pos[9:0] m_close_pos[9:0]
//                      m_bracket_kind[1:0] m_status[1:0]
//
// One character beat is taken every cycle while s_ready is high; the four stack depths, the
// position and the error flag update in the cycle of the beat.
// A close pops the stack RAM, whose read data is registered; a result reaches m_
// through a pending register and then the output register.
// Input stalls only when both the pending register and m_ are full and m_ready is low.
// Reset (aresetn, synchronous) clears depths, position, error and the valid flags;
// the stack RAM needs no clearing since only pushed entries are popped.
`default_nettype none
module bracket_structure_pair_matcher #(
    parameter int MAX_LEN = bspm_pkg::MAX_LEN_DEFAULT
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_symbol,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [bspm_pkg::POS_W-1:0] m_open_pos,
    output logic      [bspm_pkg::POS_W-1:0] m_close_pos,
    output logic      [1:0]                 m_bracket_kind,
    output logic      [1:0]                 m_status
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int MW = AW + 2;

    logic                       mem_we, mem_re;
    logic [MW-1:0]              mem_waddr, mem_raddr;
    logic [bspm_pkg::POS_W-1:0] mem_wdata, mem_rdata;
    logic                       pend_take, pend_valid;
    bspm_pkg::pend_t            pend;

    bspm_stack_ctrl #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .MW      (MW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_symbol   (s_symbol),
        .s_last     (s_last),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .pend_take  (pend_take),
        .pend_valid (pend_valid),
        .pend       (pend)
    );

    bspm_ram #(
        .WIDTH (bspm_pkg::POS_W),
        .DEPTH (1 << MW)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bspm_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pend_valid     (pend_valid),
        .pend           (pend),
        .stack_rdata    (mem_rdata),
        .pend_take      (pend_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_open_pos     (m_open_pos),
        .m_close_pos    (m_close_pos),
        .m_bracket_kind (m_bracket_kind),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

// ===== bench/bracket_structure_pair_matcher_tb.sv =====
`default_nettype none
module bracket_structure_pair_matcher_tb;
    import bspm_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEFAULT;
    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef struct packed {
        logic [POS_W-1:0] open_pos;
        logic [POS_W-1:0] close_pos;
        logic [1:0]       kind;
        logic [1:0]       status;
    } pair_t;

    class pair_checker;
        logic [POS_W-1:0] stack_mem [NKINDS][MAX_LEN];
        int unsigned      depth [NKINDS];
        int unsigned      pos;
        bit               err_latched;
        pair_t            pending_pairs [$];
        int               errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            foreach (depth[k]) depth[k] = 0;
            pos = 0;
            err_latched = 1'b0;
        endfunction

        function int outstanding();
            return pending_pairs.size();
        endfunction

        function void take_symbol(logic [7:0] sym, logic last);
            logic [1:0] kind;
            bit         is_bracket;
            bit         is_open;
            pair_t      exp;
            is_bracket = 1'b1;
            is_open    = 1'b0;
            kind       = KIND_ROUND;
            case (sym)
                CH_ROUND_OPEN: begin kind = KIND_ROUND; is_open = 1'b1; end
                CH_ROUND_CLOSE: kind = KIND_ROUND;
                CH_CURLY_OPEN: begin kind = KIND_CURLY; is_open = 1'b1; end
                CH_CURLY_CLOSE: kind = KIND_CURLY;
                CH_SQUARE_OPEN: begin kind = KIND_SQUARE; is_open = 1'b1; end
                CH_SQUARE_CLOSE: kind = KIND_SQUARE;
                CH_ANGLE_OPEN: begin kind = KIND_ANGLE; is_open = 1'b1; end
                CH_ANGLE_CLOSE: kind = KIND_ANGLE;
                default: is_bracket = 1'b0;
            endcase
            if (!err_latched && sym != CH_BREAK) begin
                if (pos >= MAX_LEN) begin
                    exp.open_pos  = '0;
                    exp.close_pos = pos[POS_W-1:0];
                    exp.kind      = KIND_ROUND;
                    exp.status    = ST_TOO_LONG;
                    pending_pairs.push_back(exp);
                    err_latched = 1'b1;
                end else begin
                    if (is_bracket) begin
                        if (is_open) begin
                            if (depth[kind] < MAX_LEN) begin
                                stack_mem[kind][depth[kind]] = pos[POS_W-1:0];
                                depth[kind]++;
                            end
                        end else if (depth[kind] == 0) begin
                            exp.open_pos  = '0;
                            exp.close_pos = pos[POS_W-1:0];
                            exp.kind      = kind;
                            exp.status    = ST_UNMATCHED;
                            pending_pairs.push_back(exp);
                            err_latched = 1'b1;
                        end else begin
                            depth[kind]--;
                            exp.open_pos  = stack_mem[kind][depth[kind]];
                            exp.close_pos = pos[POS_W-1:0];
                            exp.kind      = kind;
                            exp.status    = ST_PAIR;
                            pending_pairs.push_back(exp);
                        end
                    end
                    pos++;
                end
            end
            if (last) clear_state();
        endfunction

        function void report(string field, int unsigned e, int unsigned a);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
            errors++;
        endfunction

        function void check_pair(pair_t got);
            pair_t exp;
            if (pending_pairs.size() == 0) begin
                $display({"%0t: unexpected beat, expected none, ",
                          "actual open %0d close %0d kind %0d status %0d"},
                         $time, got.open_pos, got.close_pos, got.kind, got.status);
                errors++;
                return;
            end
            exp = pending_pairs.pop_front();
            if (got.open_pos !== exp.open_pos) report("open_pos", exp.open_pos, got.open_pos);
            if (got.close_pos !== exp.close_pos) report("close_pos", exp.close_pos, got.close_pos);
            if (got.kind !== exp.kind) report("bracket_kind", exp.kind, got.kind);
            if (got.status !== exp.status) report("status", exp.status, got.status);
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_symbol;
    logic             s_last;
    logic             m_valid;
    logic             m_ready;
    logic [POS_W-1:0] m_open_pos;
    logic [POS_W-1:0] m_close_pos;
    logic [1:0]       m_bracket_kind;
    logic [1:0]       m_status;

    pair_checker predictor = new();
    logic [7:0]  symbol_q [$];
    logic [7:0]  open_ch [NKINDS] = '{CH_ROUND_OPEN, CH_CURLY_OPEN, CH_SQUARE_OPEN, CH_ANGLE_OPEN};
    logic [7:0]  close_ch [NKINDS] = '{CH_ROUND_CLOSE, CH_CURLY_CLOSE, CH_SQUARE_CLOSE,
                                       CH_ANGLE_CLOSE};
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          rx_hold_left = 0;
    int          beats_sent = 0;

    bracket_structure_pair_matcher #(.MAX_LEN(MAX_LEN)) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_open_pos     (m_open_pos),
        .m_close_pos    (m_close_pos),
        .m_bracket_kind (m_bracket_kind),
        .m_status       (m_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: held off while rx_hold_left is nonzero, otherwise random stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_left > 0) begin
                m_ready = 1'b0;
                rx_hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            predictor.check_pair('{m_open_pos, m_close_pos, m_bracket_kind, m_status});
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_symbol = sym;
        s_last   = last;
        do @(posedge aclk); while (!s_ready);
        predictor.take_symbol(sym, last);
        beats_sent++;
        @(negedge aclk);
        // drop valid once the beat is taken
        s_valid = 1'b0;
    endtask

    task automatic send_structure();
        foreach (symbol_q[i]) send_symbol(symbol_q[i], i == symbol_q.size() - 1);
    endtask

    // mostly balanced brackets; noise bytes mixed in unless clean is set
    task automatic build_balanced(input int len, input bit clean);
        int d [NKINDS];
        int r;
        int k;
        int j;
        bit found;
        foreach (d[i]) d[i] = 0;
        symbol_q = {};
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 35) begin
                k = $urandom_range(NKINDS - 1);
                symbol_q.push_back(open_ch[k]);
                d[k]++;
            end else if (r < 70) begin
                k = $urandom_range(NKINDS - 1);
                found = 1'b0;
                for (j = 0; j < NKINDS && !found; j++) begin
                    if (d[(k + j) % NKINDS] > 0) begin
                        found = 1'b1;
                        k = (k + j) % NKINDS;
                    end
                end
                if (found) begin
                    symbol_q.push_back(close_ch[k]);
                    d[k]--;
                end else begin
                    symbol_q.push_back(CH_DOT);
                end
            end else if (r < 85 || (clean && r >= 90)) begin
                symbol_q.push_back(CH_DOT);
            end else if (r < 90) begin
                symbol_q.push_back(CH_BREAK);
            end else begin
                symbol_q.push_back(8'($urandom_range(255)));
            end
        end
        if (!clean && $urandom_range(1)) begin
            foreach (d[i]) begin
                while (d[i] > 0) begin
                    symbol_q.push_back(close_ch[i]);
                    d[i]--;
                end
            end
        end
    endtask

    task automatic build_random_structure();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 70) begin
            build_balanced($urandom_range(40, 1), 1'b0);
        end else begin
            len = $urandom_range(30, 1);
            symbol_q = {};
            for (int i = 0; i < len; i++) begin
                if (r < 90) begin
                    case ($urandom_range(9))
                        8: symbol_q.push_back(CH_DOT);
                        9: symbol_q.push_back(CH_BREAK);
                        default: symbol_q.push_back($urandom_range(1) ?
                                                    open_ch[$urandom_range(3)] :
                                                    close_ch[$urandom_range(3)]);
                    endcase
                end else begin
                    symbol_q.push_back(8'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (predictor.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int positions;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_symbol = 8'h00;
        s_last   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // nested pairs of every kind, strand break, byte extremes
        symbol_q = '{CH_ROUND_OPEN, CH_CURLY_OPEN, CH_SQUARE_OPEN, CH_ANGLE_OPEN, CH_BREAK,
                     CH_DOT, 8'h00, CH_ANGLE_CLOSE, CH_SQUARE_CLOSE, CH_CURLY_CLOSE,
                     CH_ROUND_CLOSE, 8'hFF};
        send_structure();
        // unmatched close, then everything up to last is dropped
        symbol_q = '{CH_DOT, CH_ROUND_CLOSE, CH_ROUND_OPEN, CH_SQUARE_CLOSE};
        send_structure();
        symbol_q = '{CH_CURLY_CLOSE, CH_ANGLE_CLOSE};
        send_structure();
        // unmatched close on the last beat itself
        symbol_q = '{CH_SQUARE_CLOSE};
        send_structure();
        symbol_q = '{CH_ANGLE_OPEN, CH_ANGLE_CLOSE};
        send_structure();
        symbol_q = '{CH_ANGLE_CLOSE};
        send_structure();
        symbol_q = '{CH_BREAK};
        send_structure();
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            positions = beats_sent + 170;
            while (beats_sent < positions) begin
                build_random_structure();
                send_structure();
            end
        end

        // hold the receiver off while the sender keeps pushing pairs
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_left   = 400;
        symbol_q = {};
        for (int i = 0; i < 40; i++) begin
            symbol_q.push_back(open_ch[i % NKINDS]);
            symbol_q.push_back(close_ch[i % NKINDS]);
        end
        send_structure();
        wait_drained();

        // overrun the position range with clean content
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        build_balanced(1024, 1'b1);
        positions = 0;
        foreach (symbol_q[i]) if (symbol_q[i] != CH_BREAK) positions++;
        while (positions < MAX_LEN + 3) begin
            symbol_q.push_back(CH_DOT);
            positions++;
        end
        send_structure();

        s_valid = 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);
        if (predictor.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/bspm_pkg.sv
rtl/core/bspm_ram.sv
rtl/core/bspm_stack_ctrl.sv
rtl/core/bspm_out_stage.sv
rtl/core/bracket_structure_pair_matcher.sv
bench/bracket_structure_pair_matcher_tb.sv
